>>> design/segregated_extent_allocator_defines.svh
// Assertion macros shared by the segregated extent allocator modules
`ifndef SEGREGATED_EXTENT_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_EXTENT_ALLOCATOR_DEFINES_SVH

// check cons in the same cycle as ante
`define SEAX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define SEAX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/seax_pkg.sv
// Types, constants and helpers for the segregated extent allocator
package seax_pkg;

    localparam int MAX_EXTENTS = 256;
    localparam int NUM_CLASSES = 8;
    localparam int LBA_BITS    = 40;
    localparam int EXT_BITS    = $clog2(MAX_EXTENTS);
    localparam int LINK_BITS   = EXT_BITS + 1;
    localparam int CNT_BITS    = EXT_BITS + 1;
    localparam int CLS_BITS    = $clog2(NUM_CLASSES);
    localparam int BYTE_BITS   = 52;
    localparam int BLOCK_SHIFT = 12;
    localparam int NEED_BITS   = 7;

    localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(MAX_EXTENTS);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic CFG_POOL_START = 1'b0;
    localparam logic CFG_POOL_END   = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FREE    = 2'd1;
    localparam logic [1:0] ST_NO_SPARE   = 2'd2;
    localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

    typedef struct packed {
        logic       action;
        logic [3:0] size_units;
        logic [7:0] free_handle;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           handle;
        logic [LBA_BITS-1:0]  block_start;
        logic [6:0]           block_length;
        logic [1:0]           status;
        logic [BYTE_BITS-1:0] active_bytes;
        logic [BYTE_BITS-1:0] peak_bytes;
    } t_out_item;

    typedef enum logic [25:0] {
        OP_IDLE   = 26'b1,
        OP_INIT   = 26'b1 << 1,
        OP_A_RD   = 26'b1 << 2,
        OP_A_CHK  = 26'b1 << 3,
        OP_A_SPL1 = 26'b1 << 4,
        OP_A_SPL2 = 26'b1 << 5,
        OP_A_SPL3 = 26'b1 << 6,
        OP_A_SPL4 = 26'b1 << 7,
        OP_A_ACC  = 26'b1 << 8,
        OP_A_PEAK = 26'b1 << 9,
        OP_F_RD   = 26'b1 << 10,
        OP_F_LD   = 26'b1 << 11,
        OP_F_SUB  = 26'b1 << 12,
        OP_FP_RD  = 26'b1 << 13,
        OP_FP_LD  = 26'b1 << 14,
        OP_FP_W1  = 26'b1 << 15,
        OP_FP_W2  = 26'b1 << 16,
        OP_FP_W3  = 26'b1 << 17,
        OP_FQ_RD  = 26'b1 << 18,
        OP_FQ_LD  = 26'b1 << 19,
        OP_FQ_W1  = 26'b1 << 20,
        OP_FQ_W2  = 26'b1 << 21,
        OP_FQ_W3  = 26'b1 << 22,
        OP_PUSH   = 26'b1 << 23,
        OP_PUSH2  = 26'b1 << 24,
        OP_FIN    = 26'b1 << 25
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_acc;
        logic cfg_acc;
    } t_cmd;

    typedef struct packed {
        logic go_free;
        logic alloc_none;
        logic bad_handle;
        logic split_blocked;
        logic need_split;
        logic merge_p;
        logic merge_q;
        logic out_free;
    } t_stat;

    function automatic logic [CLS_BITS-1:0] class_of(input logic [LBA_BITS-1:0] len);
        logic [LBA_BITS-1:0] t;
        t = len - LBA_BITS'(1);
        if (len == '0) return '0;
        if ((t >> 3) > LBA_BITS'(NUM_CLASSES - 1)) return CLS_BITS'(NUM_CLASSES - 1);
        return t[CLS_BITS+2:3];
    endfunction

endpackage

>>> design/segregated_extent_allocator.sv
// Top level of the segregated extent allocator
//
//  channel | direction | handshake                 | payload
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_ready   | i_in_item
//  out     | out       | o_out_valid / i_out_ready | o_out_item
//
// Allocate: read and check the head extent, split it if it is longer than needed.
// No free extent or a bad handle goes straight to finish, no spare entry after the
// check. Free: read the extent, merge each free neighbor, push it on its list. The
// single read port of the extent tables allows one table access per step. A config
// write reloads the pool in the init state; no clearing pass after reset.
// One item at a time; the result register lets the next item in while it waits.
module segregated_extent_allocator import seax_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [LBA_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item
);

    t_cmd  w_cmd;
    t_stat w_stat;

    seax_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_in_valid  (i_in_valid),
        .i_stat      (w_stat),
        .o_cfg_ready (o_cfg_ready),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    seax_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> design/seax_ctrl.sv
// Sequencer for allocate, free and pool setup
`include "segregated_extent_allocator_defines.svh"
module seax_ctrl import seax_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_valid,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_cfg_ready,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_op r_state;
    t_op n_state;

    assign o_cfg_ready   = (r_state == OP_IDLE);
    assign o_in_ready    = (r_state == OP_IDLE) && !i_cfg_valid;
    assign o_cmd.op      = r_state;
    assign o_cmd.cfg_acc = o_cfg_ready && i_cfg_valid;
    assign o_cmd.in_acc  = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            OP_IDLE: begin
                if (i_cfg_valid) begin
                    n_state = OP_INIT;
                end else if (i_in_valid) begin
                    if (i_stat.go_free) begin
                        n_state = i_stat.bad_handle ? OP_FIN : OP_F_RD;
                    end else begin
                        n_state = i_stat.alloc_none ? OP_FIN : OP_A_RD;
                    end
                end
            end
            OP_INIT:   n_state = OP_IDLE;
            OP_A_RD:   n_state = OP_A_CHK;
            OP_A_CHK: begin
                if (i_stat.split_blocked) n_state = OP_FIN;
                else if (i_stat.need_split) n_state = OP_A_SPL1;
                else n_state = OP_A_ACC;
            end
            OP_A_SPL1: n_state = OP_A_SPL2;
            OP_A_SPL2: n_state = OP_A_SPL3;
            OP_A_SPL3: n_state = OP_A_SPL4;
            OP_A_SPL4: n_state = OP_A_ACC;
            OP_A_ACC:  n_state = OP_A_PEAK;
            OP_A_PEAK: n_state = OP_FIN;
            OP_F_RD:   n_state = OP_F_LD;
            OP_F_LD:   n_state = OP_F_SUB;
            OP_F_SUB: begin
                if (i_stat.merge_p) n_state = OP_FP_RD;
                else if (i_stat.merge_q) n_state = OP_FQ_RD;
                else n_state = OP_PUSH;
            end
            OP_FP_RD:  n_state = OP_FP_LD;
            OP_FP_LD:  n_state = OP_FP_W1;
            OP_FP_W1:  n_state = OP_FP_W2;
            OP_FP_W2:  n_state = OP_FP_W3;
            OP_FP_W3:  n_state = i_stat.merge_q ? OP_FQ_RD : OP_PUSH;
            OP_FQ_RD:  n_state = OP_FQ_LD;
            OP_FQ_LD:  n_state = OP_FQ_W1;
            OP_FQ_W1:  n_state = OP_FQ_W2;
            OP_FQ_W2:  n_state = OP_FQ_W3;
            OP_FQ_W3:  n_state = OP_PUSH;
            OP_PUSH:   n_state = OP_PUSH2;
            OP_PUSH2:  n_state = OP_FIN;
            OP_FIN:    n_state = i_stat.out_free ? OP_IDLE : OP_FIN;
            default:   n_state = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SEAX_ASSERT_NXT(a_cfg_to_init, o_cmd.cfg_acc, r_state == OP_INIT, "config item not followed by init")
    `SEAX_ASSERT_IMP(a_one_accept, 1'b1, !(o_cmd.cfg_acc && o_cmd.in_acc), "two items accepted at once")
    `SEAX_ASSERT_NXT(a_fin_exit, (r_state == OP_FIN) && i_stat.out_free, r_state == OP_IDLE, "stuck in finish")

endmodule

>>> design/seax_dp.sv
// Extent tables, free lists, spare entries, byte counters and result register
`include "segregated_extent_allocator_defines.svh"
module seax_dp import seax_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  t_in_item            i_in_item,
    input  logic                i_cfg_index,
    input  logic [LBA_BITS-1:0] i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item
);

    // tables
    logic [LBA_BITS-1:0]  m_start [MAX_EXTENTS];
    logic [LBA_BITS-1:0]  m_len   [MAX_EXTENTS];
    logic [LINK_BITS-1:0] m_aprev [MAX_EXTENTS];
    logic [LINK_BITS-1:0] m_anext [MAX_EXTENTS];
    logic [LINK_BITS-1:0] m_fprev [MAX_EXTENTS];
    logic [LINK_BITS-1:0] m_fnext [MAX_EXTENTS];
    logic [EXT_BITS-1:0]  m_stk   [MAX_EXTENTS];

    logic [LBA_BITS-1:0]  m_rd_start;
    logic [LBA_BITS-1:0]  m_rd_len;
    logic [LINK_BITS-1:0] m_rd_aprev;
    logic [LINK_BITS-1:0] m_rd_anext;
    logic [LINK_BITS-1:0] m_rd_fprev;
    logic [LINK_BITS-1:0] m_rd_fnext;
    logic [EXT_BITS-1:0]  r_stk_top;

    // control state
    logic [LBA_BITS-1:0]  r_pool_start;
    logic [LBA_BITS-1:0]  r_pool_end;
    logic [MAX_EXTENTS-1:0] r_valid;
    logic [MAX_EXTENTS-1:0] r_free;
    logic [LINK_BITS-1:0] r_head [NUM_CLASSES];
    logic [CNT_BITS-1:0]  r_rc;
    logic [CNT_BITS-1:0]  r_nf;
    logic [BYTE_BITS-1:0] r_active;
    logic [BYTE_BITS-1:0] r_peak;
    logic                 r_out_valid;

    // working registers
    logic [NEED_BITS-1:0] r_need;
    logic [EXT_BITS-1:0]  r_e;
    logic [EXT_BITS-1:0]  r_n;
    logic [CLS_BITS-1:0]  r_cls;
    logic [LBA_BITS-1:0]  r_start;
    logic [LBA_BITS-1:0]  r_len;
    logic [LINK_BITS-1:0] r_aprev;
    logic [LINK_BITS-1:0] r_anext;
    logic [LINK_BITS-1:0] r_old;
    logic [LBA_BITS-1:0]  r_nb_start;
    logic [LBA_BITS-1:0]  r_nb_len;
    logic [LINK_BITS-1:0] r_nb_alink;
    logic [LINK_BITS-1:0] r_nb_fprev;
    logic [LINK_BITS-1:0] r_nb_fnext;
    logic [7:0]           r_res_handle;
    logic [LBA_BITS-1:0]  r_res_start;
    logic [6:0]           r_res_len;
    logic [1:0]           r_status;
    t_out_item            r_out;

    // combinational
    logic [3:0]           w_uc;
    logic [NEED_BITS-1:0] w_need_in;
    logic [CLS_BITS-1:0]  w_base;
    logic                 w_found;
    logic [CLS_BITS-1:0]  w_fcls;
    logic [EXT_BITS-1:0]  w_h;
    logic                 w_bad;
    logic [LBA_BITS-1:0]  w_diff;
    logic [LBA_BITS-1:0]  w_init_len;
    logic [CLS_BITS-1:0]  w_init_cls;
    logic [CLS_BITS-1:0]  w_len_cls;
    logic [CLS_BITS-1:0]  w_nb_cls;
    logic                 w_spare_empty;
    logic                 w_need_split;
    logic [EXT_BITS-1:0]  w_pop;
    logic [CNT_BITS-1:0]  w_rc_m1;
    logic [EXT_BITS-1:0]  w_rel;
    logic                 w_rel_we;
    logic                 w_out_free;
    logic [EXT_BITS-1:0]  w_ra;
    logic [EXT_BITS-1:0]  w_wa;
    logic                 w_we_start;
    logic                 w_we_len;
    logic                 w_we_aprev;
    logic                 w_we_anext;
    logic                 w_we_fprev;
    logic                 w_we_fnext;
    logic [LBA_BITS-1:0]  w_wd_start;
    logic [LBA_BITS-1:0]  w_wd_len;
    logic [LINK_BITS-1:0] w_wd_aprev;
    logic [LINK_BITS-1:0] w_wd_anext;
    logic [LINK_BITS-1:0] w_wd_fprev;
    logic [LINK_BITS-1:0] w_wd_fnext;

    assign w_uc = (i_in_item.size_units == 4'd0) ? 4'd1 :
                  (i_in_item.size_units > 4'd8)  ? 4'd8 : i_in_item.size_units;
    assign w_need_in = {w_uc, 3'b000};
    assign w_base    = CLS_BITS'(w_uc - 4'd1);
    assign w_h       = i_in_item.free_handle[EXT_BITS-1:0];
    assign w_bad     = !r_valid[w_h] || r_free[w_h];

    always_comb begin
        w_found = 1'b0;
        w_fcls  = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (CLS_BITS'(c) >= w_base && r_head[c] != NIL) begin
                w_found = 1'b1;
                w_fcls  = CLS_BITS'(c);
            end
        end
    end

    assign w_diff        = r_pool_end - r_pool_start;
    assign w_init_len    = (r_pool_end > r_pool_start) ? {w_diff[LBA_BITS-1:3], 3'b000} : '0;
    assign w_init_cls    = class_of(w_init_len);
    assign w_len_cls     = class_of(r_len);
    assign w_nb_cls      = class_of(r_nb_len);
    assign w_spare_empty = (r_rc == '0) && (r_nf == CNT_BITS'(MAX_EXTENTS));
    assign w_need_split  = m_rd_len > LBA_BITS'(r_need);
    assign w_pop         = (r_rc != '0) ? r_stk_top : r_nf[EXT_BITS-1:0];
    assign w_rc_m1       = r_rc - CNT_BITS'(1);
    assign w_rel         = (i_cmd.op == OP_FP_W2) ? r_aprev[EXT_BITS-1:0] : r_anext[EXT_BITS-1:0];
    assign w_rel_we      = (i_cmd.op == OP_FP_W2) || (i_cmd.op == OP_FQ_W2);
    assign w_out_free    = !r_out_valid || i_out_ready;

    assign o_stat.go_free       = (i_in_item.action == ACT_FREE);
    assign o_stat.alloc_none    = !w_found;
    assign o_stat.bad_handle    = w_bad;
    assign o_stat.split_blocked = w_need_split && w_spare_empty;
    assign o_stat.need_split    = w_need_split;
    assign o_stat.merge_p       = (r_aprev != NIL) && r_free[r_aprev[EXT_BITS-1:0]];
    assign o_stat.merge_q       = (r_anext != NIL) && r_free[r_anext[EXT_BITS-1:0]];
    assign o_stat.out_free      = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        unique case (i_cmd.op) inside
            OP_FP_RD: w_ra = r_aprev[EXT_BITS-1:0];
            OP_FQ_RD: w_ra = r_anext[EXT_BITS-1:0];
            default:  w_ra = r_e;
        endcase
    end

    always_comb begin
        w_wa       = r_e;
        w_we_start = 1'b0;
        w_we_len   = 1'b0;
        w_we_aprev = 1'b0;
        w_we_anext = 1'b0;
        w_we_fprev = 1'b0;
        w_we_fnext = 1'b0;
        w_wd_start = r_start;
        w_wd_len   = r_len;
        w_wd_aprev = r_aprev;
        w_wd_anext = r_anext;
        w_wd_fprev = NIL;
        w_wd_fnext = NIL;
        unique case (i_cmd.op) inside
            OP_INIT: begin
                w_wa       = '0;
                w_we_start = 1'b1;
                w_we_len   = 1'b1;
                w_we_aprev = 1'b1;
                w_we_anext = 1'b1;
                w_we_fprev = 1'b1;
                w_we_fnext = 1'b1;
                w_wd_start = r_pool_start;
                w_wd_len   = w_init_len;
                w_wd_aprev = NIL;
                w_wd_anext = NIL;
            end
            OP_A_CHK: begin
                w_wa       = m_rd_fnext[EXT_BITS-1:0];
                w_we_fprev = (m_rd_fnext != NIL) && !(w_need_split && w_spare_empty);
            end
            OP_A_SPL1: begin
                w_wa       = r_n;
                w_we_start = 1'b1;
                w_we_len   = 1'b1;
                w_we_aprev = 1'b1;
                w_we_anext = 1'b1;
                w_wd_len   = LBA_BITS'(r_need);
                w_wd_anext = {1'b0, r_e};
            end
            OP_A_SPL2: begin
                w_wa       = r_aprev[EXT_BITS-1:0];
                w_we_anext = (r_aprev != NIL);
                w_wd_anext = {1'b0, r_n};
            end
            OP_A_SPL3: begin
                w_we_start = 1'b1;
                w_we_len   = 1'b1;
                w_we_aprev = 1'b1;
                w_we_fprev = 1'b1;
                w_we_fnext = 1'b1;
                w_wd_aprev = {1'b0, r_n};
                w_wd_fnext = r_head[w_len_cls];
            end
            OP_A_SPL4, OP_PUSH2: begin
                w_wa       = r_old[EXT_BITS-1:0];
                w_we_fprev = (r_old != NIL);
                w_wd_fprev = {1'b0, r_e};
            end
            OP_FP_W1, OP_FQ_W1: begin
                w_wa       = r_nb_fnext[EXT_BITS-1:0];
                w_we_fprev = (r_nb_fnext != NIL);
                w_wd_fprev = r_nb_fprev;
            end
            OP_FP_W2, OP_FQ_W2: begin
                w_wa       = r_nb_fprev[EXT_BITS-1:0];
                w_we_fnext = (r_nb_fprev != NIL);
                w_wd_fnext = r_nb_fnext;
            end
            OP_FP_W3: begin
                w_wa       = r_nb_alink[EXT_BITS-1:0];
                w_we_anext = (r_nb_alink != NIL);
                w_wd_anext = {1'b0, r_e};
            end
            OP_FQ_W3: begin
                w_wa       = r_nb_alink[EXT_BITS-1:0];
                w_we_aprev = (r_nb_alink != NIL);
                w_wd_aprev = {1'b0, r_e};
            end
            OP_PUSH: begin
                w_we_start = 1'b1;
                w_we_len   = 1'b1;
                w_we_aprev = 1'b1;
                w_we_anext = 1'b1;
                w_we_fprev = 1'b1;
                w_we_fnext = 1'b1;
                w_wd_fnext = r_head[w_len_cls];
            end
            default: begin
                w_wa = r_e;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we_start) m_start[w_wa] <= w_wd_start;
        if (w_we_len)   m_len[w_wa]   <= w_wd_len;
        if (w_we_aprev) m_aprev[w_wa] <= w_wd_aprev;
        if (w_we_anext) m_anext[w_wa] <= w_wd_anext;
        if (w_we_fprev) m_fprev[w_wa] <= w_wd_fprev;
        if (w_we_fnext) m_fnext[w_wa] <= w_wd_fnext;
        m_rd_start <= m_start[w_ra];
        m_rd_len   <= m_len[w_ra];
        m_rd_aprev <= m_aprev[w_ra];
        m_rd_anext <= m_anext[w_ra];
        m_rd_fprev <= m_fprev[w_ra];
        m_rd_fnext <= m_fnext[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_rel_we) m_stk[r_rc[EXT_BITS-1:0]] <= w_rel;
        r_stk_top <= m_stk[w_rc_m1[EXT_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_start <= '0;
            r_pool_end   <= '0;
            r_valid      <= '0;
            r_free       <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) r_head[c] <= NIL;
            r_rc         <= '0;
            r_nf         <= '0;
            r_active     <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.cfg_acc) begin
                if (i_cfg_index == CFG_POOL_START) r_pool_start <= i_cfg_data;
                else r_pool_end <= i_cfg_data;
            end
            if (w_rel_we) begin
                r_valid[w_rel] <= 1'b0;
                r_free[w_rel]  <= 1'b0;
                r_rc           <= r_rc + CNT_BITS'(1);
            end
            if ((i_cmd.op == OP_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op) inside
                OP_INIT: begin
                    r_valid  <= (w_init_len != '0) ? MAX_EXTENTS'(1) : '0;
                    r_free   <= (w_init_len != '0) ? MAX_EXTENTS'(1) : '0;
                    for (int c = 0; c < NUM_CLASSES; c++) begin
                        r_head[c] <= ((w_init_len != '0) && (CLS_BITS'(c) == w_init_cls)) ?
                                     '0 : NIL;
                    end
                    r_rc     <= '0;
                    r_nf     <= (w_init_len != '0) ? CNT_BITS'(1) : '0;
                    r_active <= '0;
                end
                OP_A_CHK: begin
                    if (!(w_need_split && w_spare_empty)) begin
                        r_head[r_cls] <= m_rd_fnext;
                        r_free[r_e]   <= 1'b0;
                        if (w_need_split) begin
                            if (r_rc != '0) r_rc <= w_rc_m1;
                            else r_nf <= r_nf + CNT_BITS'(1);
                        end
                    end
                end
                OP_A_SPL1: begin
                    r_valid[r_n] <= 1'b1;
                    r_free[r_n]  <= 1'b0;
                end
                OP_A_SPL3, OP_PUSH: begin
                    r_head[w_len_cls] <= {1'b0, r_e};
                    r_free[r_e]       <= 1'b1;
                end
                OP_A_ACC: begin
                    r_active <= r_active + (BYTE_BITS'(r_res_len) << BLOCK_SHIFT);
                end
                OP_A_PEAK: begin
                    if (r_active > r_peak) r_peak <= r_active;
                end
                OP_F_SUB: begin
                    r_active <= r_active - (BYTE_BITS'(r_len) << BLOCK_SHIFT);
                end
                OP_FP_W1, OP_FQ_W1: begin
                    if (r_nb_fprev == NIL) r_head[w_nb_cls] <= r_nb_fnext;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_need      <= w_need_in;
            r_cls       <= w_fcls;
            r_res_start <= '0;
            r_res_len   <= '0;
            if (i_in_item.action == ACT_FREE) begin
                r_e          <= w_h;
                r_res_handle <= i_in_item.free_handle;
                r_status     <= w_bad ? ST_BAD_HANDLE : ST_OK;
            end else begin
                r_e          <= r_head[w_fcls][EXT_BITS-1:0];
                r_res_handle <= '0;
                r_status     <= w_found ? ST_OK : ST_NO_FREE;
            end
        end
        unique case (i_cmd.op) inside
            OP_A_CHK: begin
                r_start <= m_rd_start;
                r_len   <= m_rd_len;
                r_aprev <= m_rd_aprev;
                if (w_need_split && w_spare_empty) begin
                    r_status <= ST_NO_SPARE;
                end else begin
                    r_res_start <= m_rd_start;
                    if (w_need_split) begin
                        r_n          <= w_pop;
                        r_res_handle <= 8'(w_pop);
                        r_res_len    <= r_need;
                    end else begin
                        r_res_handle <= 8'(r_e);
                        r_res_len    <= m_rd_len[6:0];
                    end
                end
            end
            OP_A_SPL2: begin
                r_start <= r_start + LBA_BITS'(r_need);
                r_len   <= r_len - LBA_BITS'(r_need);
            end
            OP_A_SPL3, OP_PUSH: begin
                r_old <= r_head[w_len_cls];
            end
            OP_F_LD: begin
                r_start <= m_rd_start;
                r_len   <= m_rd_len;
                r_aprev <= m_rd_aprev;
                r_anext <= m_rd_anext;
            end
            OP_FP_LD, OP_FQ_LD: begin
                r_nb_start <= m_rd_start;
                r_nb_len   <= m_rd_len;
                r_nb_fprev <= m_rd_fprev;
                r_nb_fnext <= m_rd_fnext;
                r_nb_alink <= (i_cmd.op == OP_FP_LD) ? m_rd_aprev : m_rd_anext;
            end
            OP_FP_W2: begin
                r_start <= r_nb_start;
                r_len   <= r_len + r_nb_len;
                r_aprev <= r_nb_alink;
            end
            OP_FQ_W2: begin
                r_len   <= r_len + r_nb_len;
                r_anext <= r_nb_alink;
            end
            OP_FIN: begin
                if (w_out_free) begin
                    r_out.handle       <= r_res_handle;
                    r_out.block_start  <= r_res_start;
                    r_out.block_length <= r_res_len;
                    r_out.status       <= r_status;
                    r_out.active_bytes <= r_active;
                    r_out.peak_bytes   <= r_peak;
                end
            end
            default: begin
                r_old <= r_old;
            end
        endcase
    end

    `SEAX_ASSERT_IMP(a_free_is_valid, 1'b1, (r_free & ~r_valid) == '0, "free entry not valid")
    `SEAX_ASSERT_IMP(a_peak_ge_active, i_cmd.op == OP_IDLE, r_peak >= r_active, "peak below active")
    `SEAX_ASSERT_IMP(a_recycle_bound, 1'b1, r_rc <= r_nf, "more recycled entries than taken")

endmodule

>>> sim/segregated_extent_allocator_test.sv
// Testbench for the segregated extent allocator: directed and random traffic checked against a predictor
`timescale 1ns / 1ps

module segregated_extent_allocator_test;
    import seax_pkg::*;

    localparam int LINK_NIL  = MAX_EXTENTS;
    localparam int STALL_MAX = 5000;

    class extent_scoreboard;
        logic [LBA_BITS-1:0]  pool_start;
        logic [LBA_BITS-1:0]  pool_end;
        logic [LBA_BITS-1:0]  ext_start [MAX_EXTENTS];
        logic [LBA_BITS-1:0]  ext_len [MAX_EXTENTS];
        bit                   ext_free [MAX_EXTENTS];
        bit                   ext_valid [MAX_EXTENTS];
        int                   addr_prev [MAX_EXTENTS];
        int                   addr_next [MAX_EXTENTS];
        int                   list_prev [MAX_EXTENTS];
        int                   list_next [MAX_EXTENTS];
        int                   head [NUM_CLASSES];
        int                   spares [$];
        logic [BYTE_BITS-1:0] active;
        logic [BYTE_BITS-1:0] peak;
        int                   live [$];
        t_out_item            expected [$];
        int                   errors;

        function new();
            pool_start = '0;
            pool_end   = '0;
            peak       = '0;
            errors     = 0;
            rebuild();
        endfunction

        function int size_class(logic [LBA_BITS-1:0] len);
            logic [LBA_BITS-1:0] c;
            if (len == '0) return 0;
            c = (len - 1) >> 3;
            return (c > NUM_CLASSES - 1) ? NUM_CLASSES - 1 : int'(c);
        endfunction

        function void push_list(int e);
            int c;
            c = size_class(ext_len[e]);
            list_next[e] = head[c];
            list_prev[e] = LINK_NIL;
            if (head[c] != LINK_NIL) list_prev[head[c]] = e;
            head[c] = e;
            ext_free[e] = 1;
        endfunction

        function void unlink(int e);
            int c;
            c = size_class(ext_len[e]);
            if (list_next[e] != LINK_NIL) list_prev[list_next[e]] = list_prev[e];
            if (list_prev[e] == LINK_NIL) head[c] = list_next[e];
            else list_next[list_prev[e]] = list_next[e];
            list_next[e] = LINK_NIL;
            list_prev[e] = LINK_NIL;
            ext_free[e] = 0;
        endfunction

        function void retire(int e);
            ext_valid[e] = 0;
            ext_free[e]  = 0;
            spares.push_back(e);
        endfunction

        function void rebuild();
            logic [LBA_BITS-1:0] len;
            int e;
            spares.delete();
            live.delete();
            for (int i = 0; i < MAX_EXTENTS; i++) begin
                ext_start[i] = '0;
                ext_len[i]   = '0;
                ext_free[i]  = 0;
                ext_valid[i] = 0;
                addr_prev[i] = LINK_NIL;
                addr_next[i] = LINK_NIL;
                list_prev[i] = LINK_NIL;
                list_next[i] = LINK_NIL;
                spares.push_back(MAX_EXTENTS - 1 - i);
            end
            for (int i = 0; i < NUM_CLASSES; i++) head[i] = LINK_NIL;
            active = '0;
            len = '0;
            if (pool_end > pool_start) len = (pool_end - pool_start) & ~(LBA_BITS'(7));
            if (len != '0) begin
                e = spares.pop_back();
                ext_start[e] = pool_start;
                ext_len[e]   = len;
                ext_valid[e] = 1;
                push_list(e);
            end
        endfunction

        function void write_reg(logic idx, logic [LBA_BITS-1:0] data);
            if (idx == CFG_POOL_START) pool_start = data;
            else pool_end = data;
            rebuild();
        endfunction

        function void note_request(t_in_item it);
            t_out_item r;
            int u, need, e, n, p, q, pp, qq, k;
            r = '0;
            if (it.action == ACT_ALLOC) begin
                u = it.size_units;
                if (u < 1) u = 1;
                if (u > 8) u = 8;
                need = u * 8;
                e = LINK_NIL;
                for (int c = size_class(need); c < NUM_CLASSES; c++) begin
                    if (e == LINK_NIL && head[c] != LINK_NIL) e = head[c];
                end
                if (e == LINK_NIL) begin
                    r.status = ST_NO_FREE;
                end else if (ext_len[e] > need && spares.size() == 0) begin
                    r.status = ST_NO_SPARE;
                end else begin
                    n = e;
                    unlink(e);
                    if (ext_len[e] > need) begin
                        n = spares.pop_back();
                        ext_start[n] = ext_start[e];
                        ext_len[n]   = need;
                        ext_valid[n] = 1;
                        ext_free[n]  = 0;
                        list_prev[n] = LINK_NIL;
                        list_next[n] = LINK_NIL;
                        addr_prev[n] = addr_prev[e];
                        addr_next[n] = e;
                        if (addr_prev[e] != LINK_NIL) addr_next[addr_prev[e]] = n;
                        addr_prev[e] = n;
                        ext_start[e] = ext_start[e] + need;
                        ext_len[e]   = ext_len[e] - need;
                        push_list(e);
                    end
                    r.status       = ST_OK;
                    r.handle       = n[7:0];
                    r.block_start  = ext_start[n];
                    r.block_length = ext_len[n][6:0];
                    active = active + (BYTE_BITS'(ext_len[n]) << BLOCK_SHIFT);
                    if (active > peak) peak = active;
                    live.push_back(n);
                end
            end else begin
                e = it.free_handle;
                r.handle = it.free_handle;
                if (!ext_valid[e] || ext_free[e]) begin
                    r.status = ST_BAD_HANDLE;
                end else begin
                    r.status = ST_OK;
                    p = addr_prev[e];
                    q = addr_next[e];
                    active = active - (BYTE_BITS'(ext_len[e]) << BLOCK_SHIFT);
                    if (p != LINK_NIL && ext_free[p]) begin
                        pp = addr_prev[p];
                        unlink(p);
                        ext_start[e] = ext_start[p];
                        ext_len[e]   = ext_len[e] + ext_len[p];
                        addr_prev[e] = pp;
                        if (pp != LINK_NIL) addr_next[pp] = e;
                        retire(p);
                    end
                    if (q != LINK_NIL && ext_free[q]) begin
                        qq = addr_next[q];
                        unlink(q);
                        ext_len[e]   = ext_len[e] + ext_len[q];
                        addr_next[e] = qq;
                        if (qq != LINK_NIL) addr_prev[qq] = e;
                        retire(q);
                    end
                    push_list(e);
                    for (k = 0; k < live.size(); k++) begin
                        if (live[k] == e) begin
                            live.delete(k);
                            break;
                        end
                    end
                end
            end
            r.active_bytes = active;
            r.peak_bytes   = peak;
            expected.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item w;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: %p", got);
                return;
            end
            w = expected.pop_front();
            if (got.handle !== w.handle || got.block_start !== w.block_start ||
                got.block_length !== w.block_length || got.status !== w.status ||
                got.active_bytes !== w.active_bytes || got.peak_bytes !== w.peak_bytes) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p actual %p", w, got);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [LBA_BITS-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;

    extent_scoreboard sb;
    int               stall_cycles;
    bit               no_idle;

    segregated_extent_allocator i_dut (.*);

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= (pick_gap() == 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(t_in_item it);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_item  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_pool(logic idx, logic [LBA_BITS-1:0] data);
        wait_idle();
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic alloc(logic [3:0] units);
        t_in_item it;
        it.action      = ACT_ALLOC;
        it.size_units  = units;
        it.free_handle = 8'($urandom);
        send_item(it);
    endtask

    task automatic release_handle(logic [7:0] h);
        t_in_item it;
        it.action      = ACT_FREE;
        it.size_units  = 4'($urandom);
        it.free_handle = h;
        send_item(it);
    endtask

    task automatic random_items(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 5) alloc(4'($urandom));
            else if (r < 50) alloc(4'($urandom_range(1, 8)));
            else if (r < 90 && sb.live.size() != 0)
                release_handle(8'(sb.live[$urandom_range(0, sb.live.size() - 1)]));
            else release_handle(8'($urandom));
        end
    endtask

    initial begin
        sb           = new();
        no_idle      = 0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_POOL_START;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        alloc(4'd1);
        release_handle(8'd0);
        release_handle(8'd255);

        write_pool(CFG_POOL_START, 40'h100);
        write_pool(CFG_POOL_END, 40'h100 + 40'd1003);
        for (int s = 0; s < 16; s++) alloc(4'(s));
        release_handle(8'(sb.live[1]));
        release_handle(8'(sb.live[1]));
        release_handle(8'(sb.live[0]));
        release_handle(8'(sb.live[0]));
        release_handle(8'd255);
        random_items(250);

        no_idle = 1;
        write_pool(CFG_POOL_START, {LBA_BITS{1'b1}} - 40'd4096);
        write_pool(CFG_POOL_END, {LBA_BITS{1'b1}});
        random_items(80);
        no_idle = 0;
        random_items(120);

        write_pool(CFG_POOL_END, 40'd5);
        alloc(4'd8);
        release_handle(8'd0);

        write_pool(CFG_POOL_START, '0);
        write_pool(CFG_POOL_END, {LBA_BITS{1'b1}});
        repeat (258) alloc(4'd1);
        release_handle(8'(sb.live[10]));
        release_handle(8'(sb.live[10]));
        random_items(150);

        wait_idle();
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
